>>> design/sdtq_pkg.sv
// sdtq_pkg: shared types, widths and helpers for the sorted deadline timeout queue
// used by sdtq_cell, sdtq_chain and sorted_deadline_timeout_queue; no dependencies
package sdtq_pkg;

   localparam int TIME_W       = 32;
   localparam int TASK_W       = 16;
   localparam int DELAY_W      = 20;
   localparam int CAPACITY_DEF = 32;
   localparam int MAX_RESULTS  = 32;
   localparam int BURST_W      = $clog2(MAX_RESULTS);

   // transaction codes
   localparam logic OP_ADD      = 1'b0;
   localparam logic OP_TICK     = 1'b1;
   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_WAKE   = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic              insert;
      logic              pop;
      logic [TIME_W-1:0] new_deadline;
      logic [TASK_W-1:0] new_task;
      logic [TIME_W-1:0] now;
   } ctrl_type;

   // a strictly later than b, by wrapping difference
   function automatic logic later_than(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] d;
      d = a - b;
      return (d != '0) && !d[TIME_W-1];
   endfunction

endpackage

>>> design/sdtq_cell.sv
// sdtq_cell: one slot of the sorted chain, holds a deadline and a task id
// depends on sdtq_pkg
module sdtq_cell #(
   parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF,
   parameter int IDX      = 0,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  sdtq_pkg::ctrl_type          ctrl,
   input  logic [CW-1:0]               count,
   input  logic                        left_take,
   input  logic [sdtq_pkg::TIME_W-1:0] left_deadline,
   input  logic [sdtq_pkg::TASK_W-1:0] left_task,
   input  logic [sdtq_pkg::TIME_W-1:0] right_deadline,
   input  logic [sdtq_pkg::TASK_W-1:0] right_task,
   output logic                        take,
   output logic                        due,
   output logic [sdtq_pkg::TIME_W-1:0] deadline,
   output logic [sdtq_pkg::TASK_W-1:0] task_id
);
   import sdtq_pkg::*;

   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic [TASK_W-1:0] task_ff, task_in;
   logic              occupied;

   assign occupied = CW'(IDX) < count;

   // this slot changes on an insert: it holds a later deadline or is the first free one
   assign take = occupied ? later_than(deadline_ff, ctrl.new_deadline) : (CW'(IDX) == count);
   assign due  = !later_than(deadline_ff, ctrl.now);

   always_comb begin
      deadline_in = deadline_ff;
      task_in     = task_ff;
      if (ctrl.insert && take) begin
         if (left_take) begin
            deadline_in = left_deadline;
            task_in     = left_task;
         end else begin
            deadline_in = ctrl.new_deadline;
            task_in     = ctrl.new_task;
         end
      end else if (ctrl.pop) begin
         deadline_in = right_deadline;
         task_in     = right_task;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      task_ff     <= task_in;
   end

   assign deadline = deadline_ff;
   assign task_id  = task_ff;

endmodule

>>> design/sdtq_chain.sv
// sdtq_chain: row of sdtq_cell slots kept sorted by deadline, head at slot 0
// depends on sdtq_pkg and sdtq_cell
module sdtq_chain #(
   parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  sdtq_pkg::ctrl_type          ctrl,
   input  logic [CW-1:0]               count,
   output logic                        head_due,
   output logic                        next_due,
   output logic [sdtq_pkg::TASK_W-1:0] head_task
);
   import sdtq_pkg::*;

   logic [CAPACITY-1:0] take;
   logic [CAPACITY-1:0] due;
   logic [TIME_W-1:0]   deadline [CAPACITY];
   logic [TASK_W-1:0]   task_id  [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic              l_take;
      logic [TIME_W-1:0] l_deadline, r_deadline;
      logic [TASK_W-1:0] l_task, r_task;

      if (i == 0) begin : g_first
         assign l_take     = 1'b0;
         assign l_deadline = deadline[0];
         assign l_task     = task_id[0];
      end else begin : g_mid
         assign l_take     = take[i-1];
         assign l_deadline = deadline[i-1];
         assign l_task     = task_id[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign r_deadline = deadline[i];
         assign r_task     = task_id[i];
      end else begin : g_inner
         assign r_deadline = deadline[i+1];
         assign r_task     = task_id[i+1];
      end

      sdtq_cell #(
         .CAPACITY(CAPACITY),
         .IDX     (i),
         .CW      (CW)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .count         (count),
         .left_take     (l_take),
         .left_deadline (l_deadline),
         .left_task     (l_task),
         .right_deadline(r_deadline),
         .right_task    (r_task),
         .take          (take[i]),
         .due           (due[i]),
         .deadline      (deadline[i]),
         .task_id       (task_id[i])
      );
   end

   assign head_due  = (count != '0) && due[0];
   assign next_due  = (count > CW'(1)) && due[1];
   assign head_task = task_id[0];

endmodule

>>> design/sorted_deadline_timeout_queue.sv
// sorted_deadline_timeout_queue: top level, handshakes, time counter and drain control
// depends on sdtq_pkg and sdtq_chain
//
// Input channel req_: tuser = op (add or tick), tdata = task_id, delay_ms.
// Result channel rsp_: tuser = kind (ack or wakeup), tdata = task id, status;
// tlast marks the final result of one input transaction.
// An add stores deadline = now + delay in the sorted row of cells behind all
// entries with an equal or earlier deadline; its ack (status full when no slot
// is free) sits in the output register the next cycle.
// A tick advances the millisecond counter, then pops the head of the row once
// per cycle while it is due and the output register is free, at most 32 wakeups
// per tick; a tick with nothing due emits nothing. The drain of one head per
// cycle through the cell row sets this rate.
// A new input transaction is taken only when the drain is over and the output
// register is free or being read in that cycle. When the receiver stalls, the
// output register holds and the drain waits with it.
// Reset clears the time counter, the fill count and the output valid; the cell
// contents need no reset since only slots below the fill count are read.
module sorted_deadline_timeout_queue #(
   parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [15:0] task_id, [35:16] delay_ms, [39:36] zero
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] woken_task, [16] status, [23:17] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast
);
   import sdtq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [TASK_W-1:0] rsp_task_ff, rsp_task_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   ctrl_type          ctrl;
   logic              out_free, accept, is_add, is_tick, full;
   logic              head_due, next_due, emit, emit_last;
   logic [TASK_W-1:0] head_task;
   logic [TASK_W-1:0] req_task;
   logic [DELAY_W-1:0] req_delay;

   assign req_task  = req_tdata[TASK_W-1:0];
   assign req_delay = req_tdata[TASK_W+DELAY_W-1:TASK_W];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_add     = accept && (req_tuser == OP_ADD);
   assign is_tick    = accept && (req_tuser == OP_TICK);
   assign full       = count_ff == CW'(CAPACITY);

   assign emit      = (state_ff == ST_DRAIN) && head_due && out_free;
   assign emit_last = !next_due || (burst_ff == BURST_W'(MAX_RESULTS - 1));

   assign ctrl.insert       = is_add && !full;
   assign ctrl.pop          = emit;
   assign ctrl.new_deadline = now_ff + TIME_W'(req_delay);
   assign ctrl.new_task     = req_task;
   assign ctrl.now          = now_ff;

   sdtq_chain #(
      .CAPACITY(CAPACITY),
      .CW      (CW)
   ) u_chain (
      .clock    (clock),
      .ctrl     (ctrl),
      .count    (count_ff),
      .head_due (head_due),
      .next_due (next_due),
      .head_task(head_task)
   );

   always_comb begin
      state_in = state_ff;
      now_in   = now_ff;
      count_in = count_ff;
      burst_in = burst_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_tick) begin
               now_in   = now_ff + TIME_W'(1);
               burst_in = '0;
               state_in = ST_DRAIN;
            end else if (ctrl.insert) begin
               count_in = count_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            if (!head_due) begin
               state_in = ST_IDLE;
            end else if (emit) begin
               count_in = count_ff - CW'(1);
               burst_in = burst_ff + BURST_W'(1);
               if (emit_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (is_add) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_ACK;
         rsp_task_in   = req_task;
         rsp_status_in = full ? STATUS_FULL : STATUS_OK;
         rsp_last_in   = 1'b1;
      end else if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_WAKE;
         rsp_task_in   = head_task;
         rsp_status_in = STATUS_OK;
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         count_ff     <= '0;
         burst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         count_ff     <= count_in;
         burst_ff     <= burst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'b0, rsp_status_ff, rsp_task_ff};

endmodule

>>> tb/sorted_deadline_timeout_queue_test.sv
// sorted_deadline_timeout_queue_test: self-checking bench for the deadline timeout queue
// keeps its own sorted timeout list to predict acks and wakeups; depends on sdtq_pkg
// and the sorted_deadline_timeout_queue rtl
`timescale 1ns / 100ps

module sorted_deadline_timeout_queue_test;
   import sdtq_pkg::*;

   localparam int QUEUE_DEPTH = CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 360;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 2 * MAX_RESULTS + 8;

   typedef struct packed {
      logic              kind;
      logic [TASK_W-1:0] tid;
      logic              status;
      logic              last;
   } timeout_result_type;

   // sorted list of pending timeouts plus the results still owed by the block
   class timeout_scoreboard_type;
      logic [TIME_W-1:0]  now_ms;
      logic [TIME_W-1:0]  deadline_q[QUEUE_DEPTH];
      logic [TASK_W-1:0]  tid_q[QUEUE_DEPTH];
      int                 fill;
      timeout_result_type owed_q[$];
      int                 mismatches;
      int                 unexpected;
      int                 acks_ok;
      int                 acks_full;
      int                 wakeups;

      function new();
         now_ms = '0;
         fill = 0;
         mismatches = 0;
         unexpected = 0;
         acks_ok = 0;
         acks_full = 0;
         wakeups = 0;
      endfunction

      function bit is_after(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
         logic [TIME_W-1:0] d;
         d = a - b;
         return $signed(d) > 0;
      endfunction

      function void note_request(logic op, logic [TASK_W-1:0] tid, logic [DELAY_W-1:0] delay);
         timeout_result_type r;
         logic [TIME_W-1:0] dl;
         int pos;
         int due;
         if (op == OP_ADD) begin
            r.kind = KIND_ACK;
            r.tid = tid;
            r.last = 1'b1;
            if (fill >= QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               r.status = STATUS_OK;
               dl = now_ms + TIME_W'(delay);
               pos = 0;
               while (pos < fill && !is_after(deadline_q[pos], dl)) pos++;
               for (int i = fill; i > pos; i--) begin
                  deadline_q[i] = deadline_q[i-1];
                  tid_q[i] = tid_q[i-1];
               end
               deadline_q[pos] = dl;
               tid_q[pos] = tid;
               fill++;
            end
            owed_q.push_back(r);
         end else begin
            now_ms = now_ms + 1;
            due = 0;
            while (due < fill && due < MAX_RESULTS && !is_after(deadline_q[due], now_ms)) due++;
            for (int k = 0; k < due; k++) begin
               r.kind = KIND_WAKE;
               r.tid = tid_q[k];
               r.status = STATUS_OK;
               r.last = (k == due - 1);
               owed_q.push_back(r);
            end
            for (int i = due; i < fill; i++) begin
               deadline_q[i-due] = deadline_q[i];
               tid_q[i-due] = tid_q[i];
            end
            fill -= due;
         end
      endfunction

      function void check_response(timeout_result_type got);
         timeout_result_type want;
         if (owed_q.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("%0t: result with nothing outstanding: %s %0d task %h status %0d last %0d",
                        $realtime, "kind", got.kind, got.tid, got.status, got.last);
            return;
         end
         want = owed_q.pop_front();
         if (got.kind !== want.kind || got.tid !== want.tid ||
             got.status !== want.status || got.last !== want.last) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
               $display("%0t: mismatch: expected kind %0d task %h status %0d last %0d",
                        $realtime, want.kind, want.tid, want.status, want.last);
               $display("%0t:           got      kind %0d task %h status %0d last %0d",
                        $realtime, got.kind, got.tid, got.status, got.last);
            end
         end
         if (want.kind == KIND_WAKE) wakeups++;
         else if (want.status == STATUS_FULL) acks_full++;
         else acks_ok++;
      endfunction

      function int failures();
         return mismatches + unexpected + owed_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [15:0] task_id, [35:16] delay_ms, [39:36] zero
   logic        req_tuser = 1'b0; // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [15:0] woken_task, [16] status, [23:17] zero
   logic        rsp_tuser;        // [0] kind
   logic        rsp_tlast;

   timeout_scoreboard_type sb;
   bit  steady_phase = 1'b0;
   bit  long_hold_go = 1'b0;
   logic rsp_hold = 1'b0;
   int  items_sent = 0;
   int  ticks_sent = 0;
   int  cycles = 0;

   sorted_deadline_timeout_queue #(.CAPACITY(QUEUE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $realtime, sb.owed_q.size());
         $display("[sorted_deadline_timeout_queue] ERROR");
         $finish;
      end
   end

   // one long receiver stall, counted here while the sender keeps offering
   initial begin
      wait (long_hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // result side: check every transaction, stall in short random bursts
   initial begin
      int idle_left;
      timeout_result_type got;
      idle_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.tid = rsp_tdata[15:0];
            got.status = rsp_tdata[16];
            got.last = rsp_tlast;
            sb.check_response(got);
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (idle_left > 0) begin
            rsp_tready <= 1'b0;
            idle_left--;
         end else if (!steady_phase && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            idle_left = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_request(input logic op, input logic [TASK_W-1:0] tid,
                               input logic [DELAY_W-1:0] delay);
      int gap;
      if (!steady_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0, delay, tid};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, tid, delay);
      items_sent++;
      if (op == OP_TICK) ticks_sent++;
   endtask

   task automatic add_timeout(input logic [TASK_W-1:0] tid, input logic [DELAY_W-1:0] delay);
      push_request(OP_ADD, tid, delay);
   endtask

   // tick fields are ignored by the block, so they carry random bits
   task automatic tick_once();
      push_request(OP_TICK, TASK_W'($urandom), DELAY_W'($urandom));
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
   endtask

   // fill the list, overflow it, then tick until the short deadlines drain
   task automatic fill_burst(input int max_delay);
      while (sb.fill < QUEUE_DEPTH)
         add_timeout(TASK_W'($urandom), DELAY_W'($urandom_range(0, max_delay)));
      repeat ($urandom_range(1, 2)) add_timeout(TASK_W'($urandom), DELAY_W'($urandom));
      repeat (max_delay + 2) tick_once();
   endtask

   task automatic mixed_segment();
      int n;
      int r;
      n = $urandom_range(8, 16);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 40) tick_once();
         else if (r < 42) add_timeout(TASK_W'($urandom), DELAY_W'($urandom));
         else if (r < 52) add_timeout(TASK_W'($urandom), DELAY_W'($urandom_range(0, 200)));
         else add_timeout(TASK_W'($urandom), DELAY_W'($urandom_range(0, 12)));
      end
   endtask

   initial begin
      int target;
      bit hold_done;
      bit pause_done;
      sb = new();
      hold_done = 1'b0;
      pause_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of task id, equal deadlines, tick with all ones in ignored fields
      add_timeout(16'h0000, 20'h00000);
      add_timeout(16'hFFFF, 20'h00000);
      add_timeout(16'hA5A5, 20'h00002);
      add_timeout(16'h5A5A, 20'h00001);
      push_request(OP_TICK, 16'hFFFF, 20'hFFFFF);
      push_request(OP_TICK, 16'h0000, 20'h00000);
      tick_once();
      tick_once();
      add_timeout(16'h1111, 20'h00003);
      add_timeout(16'h2222, 20'h00001);
      add_timeout(16'h3333, 20'h00003);
      add_timeout(16'h4444, 20'h00002);
      repeat (3) tick_once();
      // full list with one shared deadline: overflow acks, then 32 wakeups in one tick
      fill_burst(0);
      // longest delay: never expires during the run
      add_timeout(16'h8001, 20'hFFFFF);
      tick_once();

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (items_sent >= target - 60) steady_phase = 1'b1;
         if (!hold_done && items_sent >= target - 300) begin
            hold_done = 1'b1;
            long_hold_go = 1'b1;
         end
         if (!pause_done && items_sent >= target - 180) begin
            pause_done = 1'b1;
            wait_all_results();
         end
         if ($urandom_range(0, 9) == 0) fill_burst($urandom_range(0, 4));
         else mixed_segment();
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d transactions (%0d ticks): %0d adds stored, %0d refused as full",
               items_sent, ticks_sent, sb.acks_ok, sb.acks_full);
      $display("%0d wakeups; mismatches %0d, unexpected results %0d, still outstanding %0d",
               sb.wakeups, sb.mismatches, sb.unexpected, sb.owed_q.size());
      if (sb.failures() == 0)
         $display("[sorted_deadline_timeout_queue] OK");
      else
         $display("[sorted_deadline_timeout_queue] ERROR");
      $finish;
   end

endmodule
